// ===== hw/rtl/sudw_pkg.sv =====
// Shared types, constants and the UUID table for the SEI user-data writer.
// No dependencies; every other file imports this package.
package sudw_pkg;

  localparam int LEN_W       = 13;
  localparam int MAX_PAYLOAD = 4096;
  localparam int FF_W        = 5;
  localparam int IDX_W       = 4;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_IDX_W-1:0] REG_CODEC_IS_HEVC = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ANNEXB_MODE   = CFG_IDX_W'(1);

  localparam logic [7:0] SEI_NAL_H264   = 8'h06;
  localparam logic [7:0] SEI_NAL_HEVC0  = 8'(39 << 1);
  localparam logic [7:0] SEI_NAL_HEVC1  = 8'h01;
  localparam logic [7:0] SEI_PTYPE_UDU  = 8'h05;
  localparam logic [7:0] SIZE_RUN_BYTE  = 8'hFF;
  localparam logic [7:0] TRAILING_BYTE  = 8'h80;
  localparam logic [7:0] SIZE_STEP      = 8'd255;
  localparam int         UUID_LEN       = 16;

  typedef struct packed {
    logic             start_req;
    logic [LEN_W-1:0] payload_length;
    logic             byte_valid;
    logic [7:0]       data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       packet_last;
  } out_item_t;

  typedef struct packed {
    logic            busy;
    logic [FF_W-1:0] ff_count;
    logic [7:0]      rem;
  } sizer_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_PREFIX,
    ST_NALH,
    ST_PTYPE,
    ST_FF,
    ST_REM,
    ST_UUID,
    ST_DATA,
    ST_TRAIL
  } state_t;

  function automatic logic [7:0] uuid_byte(input logic [IDX_W-1:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd0:  b = 8'h54;
      4'd1:  b = 8'h80;
      4'd2:  b = 8'h83;
      4'd3:  b = 8'h97;
      4'd4:  b = 8'hf0;
      4'd5:  b = 8'h23;
      4'd6:  b = 8'h47;
      4'd7:  b = 8'h4b;
      4'd8:  b = 8'hb7;
      4'd9:  b = 8'hf7;
      4'd10: b = 8'h4f;
      4'd11: b = 8'h32;
      4'd12: b = 8'hb5;
      4'd13: b = 8'h4e;
      4'd14: b = 8'h06;
      4'd15: b = 8'hac;
    endcase
    return b;
  endfunction

endpackage

// ===== hw/rtl/sudw_sizer.sv =====
// Iterative size-field unit: splits the SEI payload size into 255-runs and a remainder.
// Depends on sudw_pkg.
module sudw_sizer
  import sudw_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  logic [LEN_W-1:0] size_in,
  output sizer_status_t    status
);

  logic [LEN_W-1:0] work_r, work_nxt;
  logic [FF_W-1:0]  ff_r, ff_nxt;
  logic             busy_r, busy_nxt;
  logic [LEN_W:0]   diff;
  logic             ge;

  // one shared subtract-and-compare, one step per cycle
  assign diff = {1'b0, work_r} - {(LEN_W+1-8)'(0), SIZE_STEP};
  assign ge   = !diff[LEN_W];

  always_comb begin
    work_nxt = work_r;
    ff_nxt   = ff_r;
    busy_nxt = busy_r;
    if (load) begin
      work_nxt = size_in;
      ff_nxt   = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (ge) begin
        work_nxt = diff[LEN_W-1:0];
        ff_nxt   = ff_r + FF_W'(1);
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    work_r <= work_nxt;
    ff_r   <= ff_nxt;
  end

  assign status = '{busy: busy_r, ff_count: ff_r, rem: work_r[7:0]};

endmodule

// ===== hw/rtl/sei_user_data_packet_writer.sv =====
// Top level of the SEI user-data-unregistered packet writer.
// Depends on sudw_pkg and sudw_sizer.
//
// Wraps user content into an H.264 or HEVC user-data-unregistered SEI NAL unit,
// one byte per output transfer. A start item opens a message: the block computes
// the size field with the iterative sizer (one subtract of 255 per cycle), then
// emits the prefix (start code or 4-byte big-endian NAL length), the NAL header,
// payload type 5, the 0xFF-run size field and the 16-byte UUID, 23 to 40 bytes
// at one per cycle while out_ready is high; in_ready stays low for that whole
// burst. A content byte on the start item follows the header. Later content
// items pass straight into the output register, one per cycle while out_ready
// is high; the byte that exhausts the declared length is followed by 0x80 with
// packet_last set, which holds input until the trailer is loaded. Lengths
// above 4096 saturate, bytes with no open message are dropped, and a new start
// abandons an open message without a trailer. Configuration writes are always
// taken (cfg_ready is high); write them only while the block is idle.
module sei_user_data_packet_writer
  import sudw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  state_t state_r, state_nxt;

  logic             hevc_r, annexb_r;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic             open_r, open_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  // latched start item
  logic [LEN_W-1:0] len_r;
  logic             valid_r;
  logic [7:0]       byte_r;

  logic             out_valid_r;
  out_item_t        out_data_r;

  logic             slot_free;
  logic             in_fire;
  logic             direct;
  logic             emit;
  out_item_t        emit_item;
  logic [LEN_W-1:0] sat_len;
  logic [LEN_W-1:0] nal_len;
  logic [7:0]       prefix_byte;
  logic             hdr_done;
  sizer_status_t    sz;

  // output register frees when empty or being drained this cycle
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && slot_free;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // content byte for an open message, sent straight from idle
  assign direct = in_fire && !in_data.start_req && in_data.byte_valid &&
                  open_r && (rem_r != '0);

  assign sat_len = (in_data.payload_length > LEN_W'(MAX_PAYLOAD)) ?
                   LEN_W'(MAX_PAYLOAD) : in_data.payload_length;

  sudw_sizer u_sizer (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (in_fire && in_data.start_req),
    .size_in (sat_len + LEN_W'(UUID_LEN)),
    .status  (sz)
  );

  // header bytes + size field + UUID + content + trailer
  assign nal_len = len_r + LEN_W'(sz.ff_count) + (hevc_r ? LEN_W'(21) : LEN_W'(20));

  always_comb begin
    unique case (idx_r[1:0])
      2'd0:    prefix_byte = 8'h00;
      2'd1:    prefix_byte = 8'h00;
      2'd2:    prefix_byte = annexb_r ? 8'h00 : 8'(nal_len[LEN_W-1:8]);
      default: prefix_byte = annexb_r ? 8'h01 : nal_len[7:0];
    endcase
  end

  assign hdr_done = slot_free && (idx_r == IDX_W'(UUID_LEN - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && in_data.start_req) state_nxt = ST_DIV;
        else if (direct && rem_r == LEN_W'(1)) state_nxt = ST_TRAIL;
      end
      ST_DIV: begin
        if (!sz.busy) state_nxt = ST_PREFIX;
      end
      ST_PREFIX: begin
        if (slot_free && idx_r == IDX_W'(3)) state_nxt = ST_NALH;
      end
      ST_NALH: begin
        if (slot_free && (!hevc_r || idx_r == IDX_W'(1))) state_nxt = ST_PTYPE;
      end
      ST_PTYPE: begin
        if (slot_free) state_nxt = (sz.ff_count != '0) ? ST_FF : ST_REM;
      end
      ST_FF: begin
        if (slot_free && {1'b0, idx_r} == sz.ff_count - FF_W'(1)) state_nxt = ST_REM;
      end
      ST_REM: begin
        if (slot_free) state_nxt = ST_UUID;
      end
      ST_UUID: begin
        if (hdr_done) begin
          priority if (len_r == '0) state_nxt = ST_TRAIL;
          else if (valid_r)         state_nxt = ST_DATA;
          else                      state_nxt = ST_IDLE;
        end
      end
      ST_DATA: begin
        if (slot_free) state_nxt = (rem_r == LEN_W'(1)) ? ST_TRAIL : ST_IDLE;
      end
      ST_TRAIL: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // byte to load into the output register
  always_comb begin
    emit      = 1'b0;
    emit_item = '{out_byte: 8'h00, packet_last: 1'b0};
    unique case (state_r)
      ST_IDLE: begin
        emit               = direct;
        emit_item.out_byte = in_data.data_byte;
      end
      ST_DIV: emit = 1'b0;
      ST_PREFIX: begin
        emit               = slot_free;
        emit_item.out_byte = prefix_byte;
      end
      ST_NALH: begin
        emit               = slot_free;
        emit_item.out_byte = !hevc_r ? SEI_NAL_H264 :
                             (idx_r == '0) ? SEI_NAL_HEVC0 : SEI_NAL_HEVC1;
      end
      ST_PTYPE: begin
        emit               = slot_free;
        emit_item.out_byte = SEI_PTYPE_UDU;
      end
      ST_FF: begin
        emit               = slot_free;
        emit_item.out_byte = SIZE_RUN_BYTE;
      end
      ST_REM: begin
        emit               = slot_free;
        emit_item.out_byte = sz.rem;
      end
      ST_UUID: begin
        emit               = slot_free;
        emit_item.out_byte = uuid_byte(idx_r);
      end
      ST_DATA: begin
        emit               = slot_free;
        emit_item.out_byte = byte_r;
      end
      ST_TRAIL: begin
        emit                  = slot_free;
        emit_item.out_byte    = TRAILING_BYTE;
        emit_item.packet_last = 1'b1;
      end
      default: emit = 1'b0;
    endcase
  end

  // message bookkeeping and position counter
  always_comb begin
    rem_nxt  = rem_r;
    open_nxt = open_r;
    idx_nxt  = (state_nxt != state_r) ? '0 : (emit ? idx_r + IDX_W'(1) : idx_r);
    if (in_fire && in_data.start_req) begin
      // drop any open message
      open_nxt = 1'b0;
    end else if (direct || (state_r == ST_DATA && slot_free)) begin
      rem_nxt = rem_r - LEN_W'(1);
      if (rem_r == LEN_W'(1)) open_nxt = 1'b0;
    end else if (state_r == ST_UUID && hdr_done) begin
      rem_nxt  = len_r;
      open_nxt = (len_r != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hevc_r      <= 1'b0;
      annexb_r    <= 1'b1;
      rem_r       <= '0;
      open_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rem_r   <= rem_nxt;
      open_r  <= open_nxt;
      idx_r   <= idx_nxt;
      if (emit)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_CODEC_IS_HEVC) hevc_r   <= cfg_wdata[0];
        if (cfg_index == REG_ANNEXB_MODE)   annexb_r <= cfg_wdata[0];
      end
    end
    if (emit) out_data_r <= emit_item;
    if (in_fire && in_data.start_req) begin
      len_r   <= sat_len;
      valid_r <= in_data.byte_valid;
      byte_r  <= in_data.data_byte;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/sudw_checker.sv =====
// Port-level checker for the SEI user-data writer, bound to the top level.
// Depends on sudw_pkg and sei_user_data_packet_writer.
module sudw_checker
  import sudw_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // the last byte of a packet is always the trailing byte
  a_last_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.packet_last |-> out_data.out_byte == TRAILING_BYTE)
    else $error("packet_last on a byte other than the trailer");

  // a start transfer begins the header burst: input stalls next cycle
  a_start_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.start_req |=> !in_ready)
    else $error("input taken during header burst");

  // a start transfer leaves the output register drained
  a_start_drain: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.start_req |=> !out_valid)
    else $error("result pending right after a start transfer");

endmodule

bind sei_user_data_packet_writer sudw_checker u_sudw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/sei_user_data_packet_writer_tb.sv =====
// Self-checking bench for the SEI user-data packet writer: directed and random
// messages under random stalls, each output byte checked against a predictor.
// Depends on sudw_pkg and the sei_user_data_packet_writer RTL.
module sei_user_data_packet_writer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sudw_pkg::*;

  // Cycles to let pass after the last expected byte before touching registers
  // or ending: sizer divide plus the longest header burst, with margin.
  localparam int SETTLE_CYCLES = 64;
  // Long receiver hold-off, fired once after this many output transfers.
  localparam int HOLD_AFTER    = 400;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_QUOTA   = 45;

  localparam logic [31:0] ANNEXB_PREFIX = 32'h0000_0001;
  localparam logic [7:0] SEI_UUID [UUID_LEN] = '{
    8'h54, 8'h80, 8'h83, 8'h97, 8'hf0, 8'h23, 8'h47, 8'h4b,
    8'hb7, 8'hf7, 8'h4f, 8'h32, 8'hb5, 8'h4e, 8'h06, 8'hac
  };

  // Register settings per random phase, bit p for phase p.
  localparam logic [3:0] PHASE_HEVC   = 4'b0011;
  localparam logic [3:0] PHASE_ANNEXB = 4'b1001;

  localparam out_item_t NO_BYTE = '0;
  localparam out_item_t TRAILER = '{out_byte: TRAILING_BYTE, packet_last: 1'b1};

  // One directed row: the item, and where the answer is obvious, the typed-in
  // output bytes (up to two) instead of the predicted ones.
  typedef struct packed {
    in_item_t   item;
    logic       typed;
    logic [1:0] n_typed;
    out_item_t  r0;
    out_item_t  r1;
  } stim_row_t;

  localparam stim_row_t DIRECTED [17] = '{
    // byte with no open message: drop
    '{'{1'b0, 13'd0,    1'b1, 8'hA5}, 1'b1, 2'd0, NO_BYTE, NO_BYTE},
    // empty message: header then trailer in one item
    '{'{1'b1, 13'd0,    1'b0, 8'h00}, 1'b0, 2'd0, NO_BYTE, NO_BYTE},
    // start carrying the first content byte
    '{'{1'b1, 13'd3,    1'b1, 8'h00}, 1'b0, 2'd0, NO_BYTE, NO_BYTE},
    '{'{1'b0, 13'd0,    1'b1, 8'hFF}, 1'b1, 2'd1, '{8'hFF, 1'b0}, NO_BYTE},
    // empty content item inside a message: nothing out
    '{'{1'b0, 13'h1FFF, 1'b0, 8'hFF}, 1'b1, 2'd0, NO_BYTE, NO_BYTE},
    // last byte of the message gets the trailer
    '{'{1'b0, 13'd0,    1'b1, 8'h5A}, 1'b1, 2'd2, '{8'h5A, 1'b0}, TRAILER},
    // byte after the message closed: drop
    '{'{1'b0, 13'd0,    1'b1, 8'h11}, 1'b1, 2'd0, NO_BYTE, NO_BYTE},
    // largest length field, saturates
    '{'{1'b1, 13'h1FFF, 1'b0, 8'h00}, 1'b0, 2'd0, NO_BYTE, NO_BYTE},
    '{'{1'b0, 13'h0AAA, 1'b1, 8'h00}, 1'b1, 2'd1, '{8'h00, 1'b0}, NO_BYTE},
    // restart at exactly the maximum, abandoning the open message
    '{'{1'b1, 13'd4096, 1'b1, 8'hC3}, 1'b0, 2'd0, NO_BYTE, NO_BYTE},
    // size field just below and exactly at one full 0xFF step
    '{'{1'b1, 13'd238,  1'b0, 8'h00}, 1'b0, 2'd0, NO_BYTE, NO_BYTE},
    '{'{1'b1, 13'd239,  1'b0, 8'h00}, 1'b0, 2'd0, NO_BYTE, NO_BYTE},
    // one past the maximum
    '{'{1'b1, 13'd4097, 1'b1, 8'h3C}, 1'b0, 2'd0, NO_BYTE, NO_BYTE},
    // one-byte message finished by its own start item
    '{'{1'b1, 13'd1,    1'b1, 8'h7E}, 1'b0, 2'd0, NO_BYTE, NO_BYTE},
    '{'{1'b1, 13'd2,    1'b0, 8'h55}, 1'b0, 2'd0, NO_BYTE, NO_BYTE},
    '{'{1'b0, 13'd0,    1'b1, 8'h80}, 1'b1, 2'd1, '{8'h80, 1'b0}, NO_BYTE},
    '{'{1'b0, 13'h1555, 1'b1, 8'h01}, 1'b1, 2'd2, '{8'h01, 1'b0}, TRAILER}
  };

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor copy of the registers and message state, reset values.
  logic             cur_hevc   = 1'b0;
  logic             cur_annexb = 1'b1;
  logic [LEN_W-1:0] msg_left   = '0;
  logic             msg_open   = 1'b0;

  out_item_t expected_bytes [$];
  out_item_t want;
  int        errors        = 0;
  int        results_seen  = 0;
  int        counted_items = 0;
  bit        steady        = 1'b0;  // no idling on either side when set

  always #1 clk = ~clk;

  sei_user_data_packet_writer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  function automatic void put_byte(ref out_item_t q[$], input logic [7:0] b,
                                   input logic last);
    q.push_back('{out_byte: b, packet_last: last});
  endfunction

  // Work out the bytes one accepted item makes, and advance the message state.
  function automatic void frame_item(input in_item_t it, ref out_item_t q[$]);
    logic [LEN_W-1:0] len;
    logic [31:0]      sei_size;
    logic [31:0]      ff_run;
    logic [31:0]      nal_len;
    q.delete();
    if (it.start_req) begin
      len = (it.payload_length > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD)
                                                       : it.payload_length;
      sei_size = len + UUID_LEN;
      ff_run   = sei_size / SIZE_STEP;
      nal_len  = (cur_hevc ? 2 : 1) + 1 + ff_run + 1 + UUID_LEN + len + 1;
      // Prefix: start code, or NAL length MSB first.
      for (int i = 3; i >= 0; i--)
        put_byte(q, cur_annexb ? ANNEXB_PREFIX[8*i +: 8] : nal_len[8*i +: 8], 1'b0);
      if (cur_hevc) begin
        put_byte(q, SEI_NAL_HEVC0, 1'b0);
        put_byte(q, SEI_NAL_HEVC1, 1'b0);
      end else begin
        put_byte(q, SEI_NAL_H264, 1'b0);
      end
      put_byte(q, SEI_PTYPE_UDU, 1'b0);
      // Size field: one 0xFF per full step, then the remainder.
      repeat (ff_run) put_byte(q, SIZE_RUN_BYTE, 1'b0);
      put_byte(q, 8'(sei_size - ff_run * SIZE_STEP), 1'b0);
      for (int i = 0; i < UUID_LEN; i++)
        put_byte(q, SEI_UUID[i], 1'b0);
      msg_left = len;
      msg_open = 1'b1;
      if (msg_left == 0) begin
        put_byte(q, TRAILING_BYTE, 1'b1);
        msg_open = 1'b0;
      end
    end
    if (it.byte_valid && msg_open && msg_left != 0) begin
      put_byte(q, it.data_byte, 1'b0);
      msg_left = msg_left - 1'b1;
      if (msg_left == 0) begin
        put_byte(q, TRAILING_BYTE, 1'b1);
        msg_open = 1'b0;
      end
    end
  endfunction

  // Offer one item after a random gap and hold it until the transfer. Valid is
  // left high on return so a back-to-back item reuses it; lower it only when
  // the next call decides on a gap.
  task automatic transfer_item(input in_item_t it, input logic typed,
                               input logic [1:0] n_typed, input out_item_t r0,
                               input out_item_t r1, output int produced);
    int        gap;
    int        r;
    out_item_t bytes [$];
    r = $urandom_range(0, 99);
    if (steady || r < 60) gap = 0;
    else if (r < 92)      gap = $urandom_range(1, 3);
    else                  gap = $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    // Always run the predictor so its state tracks the block; typed rows then
    // replace its bytes with the ones written in the table.
    frame_item(it, bytes);
    if (typed) begin
      bytes.delete();
      if (n_typed > 0) bytes.push_back(r0);
      if (n_typed > 1) bytes.push_back(r1);
    end
    produced = bytes.size();
    foreach (bytes[i]) expected_bytes.push_back(bytes[i]);
  endtask

  task automatic feed(input logic start, input logic [LEN_W-1:0] len,
                      input logic valid, input logic [7:0] data);
    int       produced;
    in_item_t it;
    it = '{start_req: start, payload_length: len, byte_valid: valid, data_byte: data};
    transfer_item(it, 1'b0, 2'd0, NO_BYTE, NO_BYTE, produced);
    if (produced > 0) counted_items++;
  endtask

  // Drop valid, wait for every expected byte, then let the block go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= {(CFG_DATA_W-1)'($urandom), val};
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_CODEC_IS_HEVC)    cur_hevc   = val;
    else if (idx == REG_ANNEXB_MODE) cur_annexb = val;
  endtask

  // Write both registers, with an out-of-range index in between that must
  // leave everything alone.
  task automatic program_regs(input logic hevc, input logic annexb);
    write_reg(REG_CODEC_IS_HEVC, hevc);
    write_reg(CFG_IDX_W'($urandom_range(REG_ANNEXB_MODE + 1, (1 << CFG_IDX_W) - 1)),
              1'($urandom));
    write_reg(REG_ANNEXB_MODE, annexb);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly well-formed messages with random content; some stray bytes, empty
  // items, early restarts and overruns past the declared length.
  task automatic stream_messages(input int quota);
    int   base;
    int   len;
    int   nbytes;
    int   r;
    logic first;
    base = counted_items;
    while (counted_items - base < quota) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        feed(1'b0, LEN_W'($urandom), 1'($urandom), 8'($urandom));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55)      len = $urandom_range(0, 8);
        else if (r < 85) len = $urandom_range(9, 40);
        else if (r < 95) len = $urandom_range(230, 260);
        else             len = $urandom_range(4090, 8191);
        first = 1'($urandom);
        feed(1'b1, LEN_W'(len), first, 8'($urandom));
        // Big messages only get a few bytes before something abandons them.
        if (len > 40)       nbytes = $urandom_range(0, 4);
        else if (len == 0)  nbytes = 0;
        else                nbytes = len - first;
        if ($urandom_range(0, 9) == 0) nbytes = $urandom_range(0, nbytes);
        if ($urandom_range(0, 9) == 0) nbytes += $urandom_range(1, 3);
        repeat (nbytes) begin
          if ($urandom_range(0, 9) == 0)
            feed(1'b0, LEN_W'($urandom), 1'b0, 8'($urandom));
          feed(1'b0, LEN_W'($urandom), 1'b1, 8'($urandom));
        end
      end
    end
  endtask

  // Receiver pacing: random ready stalls, mostly short, plus one long hold-off
  // while the sender is offering, so the block backs up and stalls its input.
  initial begin : rx_pacing
    int stall_left;
    int run_left;
    int r;
    bit held;
    stall_left = 0;
    run_left   = 0;
    held       = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && results_seen >= HOLD_AFTER && in_valid) begin
        held       = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else begin
          r = $urandom_range(0, 99);
          if (steady || r < 50) stall_left = 0;
          else if (r < 92)      stall_left = $urandom_range(1, 3);
          else                  stall_left = $urandom_range(20, 60);
          run_left = $urandom_range(1, 30);
        end
      end
    end
  end

  // Check each output transfer against the oldest expected byte.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected output byte %02h last %0b", $time,
                 out_data.out_byte, out_data.packet_last);
      end else begin
        want = expected_bytes.pop_front();
        if (out_data.out_byte !== want.out_byte) begin
          errors++;
          $display("%0t: out_byte expected %02h actual %02h", $time,
                   want.out_byte, out_data.out_byte);
        end
        if (out_data.packet_last !== want.packet_last) begin
          errors++;
          $display("%0t: packet_last expected %0b actual %0b", $time,
                   want.packet_last, out_data.packet_last);
        end
      end
    end
  end

  initial begin : main_seq
    int produced;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table at the reset register values.
    for (int i = 0; i < $size(DIRECTED); i++)
      transfer_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].n_typed,
                    DIRECTED[i].r0, DIRECTED[i].r1, produced);
    settle();

    // Random phases, one per register setting; one phase runs without idling.
    for (int p = 0; p < 4; p++) begin
      steady = (p == 2);
      program_regs(PHASE_HEVC[p], PHASE_ANNEXB[p]);
      stream_messages(PHASE_QUOTA);
      settle();
    end

    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/sudw_pkg.sv
hw/rtl/sudw_sizer.sv
hw/rtl/sei_user_data_packet_writer.sv
hw/rtl/sudw_checker.sv
tb/sei_user_data_packet_writer_tb.sv
